[src/dbs_pkg.sv]
// Package for the detection box suppression block.
// Holds shared field widths, payload types and the controller-datapath command and status structs.
package dbs_pkg;
   localparam int unsigned FieldWidth = 17;
   localparam int unsigned PairWidth = 34;
   localparam logic [16:0] ThresholdReset = 17'd49152;
   localparam logic [16:0] LimitReset = 17'd26214;

   typedef enum logic [0:0] {
      REG_THRESHOLD = 1'b0,
      REG_LIMIT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic        role;
      logic [16:0] score;
      logic [16:0] box_left;
      logic [16:0] box_top;
      logic [16:0] box_right;
      logic [16:0] box_bottom;
      logic        frame_end;
   } req_type;

   typedef struct packed {
      logic        present;
      logic        out_role;
      logic [16:0] out_score;
      logic [16:0] out_left;
      logic [16:0] out_top;
      logic [16:0] out_right;
      logic [16:0] out_bottom;
      logic        last_result;
   } rsp_type;

   typedef struct packed {
      logic insert;
      logic set_role;
      logic start_cand;
      logic start_cmp;
      logic step_cmp;
      logic keep;
      logic next_cand;
      logic clear_rank;
      logic start_emit;
      logic emit_step;
      logic clear_all;
   } cmd_type;

   typedef struct packed {
      logic rank_empty;
      logic cand_done;
      logic cmp_done;
      logic cmp_hit;
      logic emit_last;
      logic kept_empty;
   } status_type;
endpackage

[src/dbs_stream_if.sv]
// Valid-ready stream interface carrying one item of a given payload type.
// Depends on nothing; the payload type is a parameter.
interface dbs_stream_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[src/detection_box_suppression.sv]
// Top level of the detection box suppression block: stream ports, register port and the
// controller and datapath. Depends on dbs_pkg, dbs_stream_if, dbs_controller, dbs_datapath.
//
// A cell item is taken and inserted into a ranked list of RANK_DEPTH boxes in descending
// score order. A role change or the frame's last item starts greedy suppression over the
// list, during which no item is taken: each candidate is compared with every box already
// kept for its role, each compare going through a multiply stage and then a compare.
// The item that changes the role waits at the input until suppression of the old role is
// done and is then taken. At frame end the kept boxes go out one per cycle while the sink
// is ready; an empty frame gives one item with present low.
module detection_box_suppression #(
   parameter int unsigned RANK_DEPTH = 64,
   parameter int unsigned KEEP_PER_ROLE = 8,
   parameter int unsigned ROLE_COUNT = 2
) (
   input  logic        clock,
   input  logic        reset,
   dbs_stream_if.sink   req,
   dbs_stream_if.source rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [16:0] threshold_ff, limit_ff;
   dbs_pkg::cmd_type cmd;
   dbs_pkg::status_type status;
   logic cur_role;

   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= dbs_pkg::ThresholdReset;
         limit_ff <= dbs_pkg::LimitReset;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1:0] == 2'b00) begin
         if (csr_paddr[2] == dbs_pkg::REG_THRESHOLD) begin
            threshold_ff <= csr_pwdata[16:0];
         end else begin
            limit_ff <= csr_pwdata[16:0];
         end
      end
   end
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[1:0] == 2'b00) begin
         csr_prdata = {15'd0, (csr_paddr[2] == dbs_pkg::REG_THRESHOLD) ? threshold_ff : limit_ff};
      end
   end

   dbs_controller #(.ROLE_COUNT(ROLE_COUNT)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_role(req.payload.role), .req_end(req.payload.frame_end),
      .req_ready(req.ready), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cur_role(cur_role), .status(status), .cmd(cmd)
   );

   dbs_datapath #(
      .RANK_DEPTH(RANK_DEPTH), .KEEP_PER_ROLE(KEEP_PER_ROLE), .ROLE_COUNT(ROLE_COUNT)
   ) u_dp (
      .clock(clock), .reset(reset), .req_item(req.payload), .threshold(threshold_ff),
      .limit(limit_ff), .cmd(cmd), .status(status), .rsp_item(rsp.payload),
      .cur_role(cur_role)
   );
endmodule

[src/dbs_datapath.sv]
// Datapath: ranked insertion list, kept store, IoU compare unit and output register.
// Depends on dbs_pkg for payload and command types.
module dbs_datapath #(
   parameter int unsigned RANK_DEPTH = 64,
   parameter int unsigned KEEP_PER_ROLE = 8,
   parameter int unsigned ROLE_COUNT = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  dbs_pkg::req_type    req_item,
   input  logic [16:0]         threshold,
   input  logic [16:0]         limit,
   input  dbs_pkg::cmd_type    cmd,
   output dbs_pkg::status_type status,
   output dbs_pkg::rsp_type    rsp_item,
   output logic                cur_role
);
   localparam int unsigned KeepDepth = KEEP_PER_ROLE * ROLE_COUNT;
   localparam int unsigned RankBits = $clog2(RANK_DEPTH + 1);
   localparam int unsigned RankIdx = (RANK_DEPTH > 1) ? $clog2(RANK_DEPTH) : 1;
   localparam int unsigned KeepBits = $clog2(KeepDepth + 1);
   localparam int unsigned KeepIdx = (KeepDepth > 1) ? $clog2(KeepDepth) : 1;
   localparam int unsigned TakeBits = $clog2(KEEP_PER_ROLE + 1);

   logic [16:0] rank_score_ff [RANK_DEPTH];
   logic [33:0] rank_h_ff [RANK_DEPTH];
   logic [33:0] rank_v_ff [RANK_DEPTH];
   logic [RankBits-1:0] rank_count_ff;
   logic [16:0] kept_score_ff [KeepDepth];
   logic [33:0] kept_h_ff [KeepDepth];
   logic [33:0] kept_v_ff [KeepDepth];
   logic        kept_role_ff [KeepDepth];
   logic [KeepBits-1:0] kept_count_ff, base_ff, cmp_ff, emit_ff;
   logic [TakeBits-1:0] taken_ff;
   logic [RankBits-1:0] cand_ff;
   logic        role_ff;
   logic [16:0] c_score_ff;
   logic [33:0] c_h_ff, c_v_ff;
   logic [33:0] inter_ff, area_a_ff, area_b_ff;
   logic        hit_ff, mul_valid_ff;
   dbs_pkg::rsp_type rsp_ff;

   logic [33:0] in_h, in_v;
   logic        in_ok;
   logic [RANK_DEPTH-1:0] below;
   assign in_h = {req_item.box_left, req_item.box_right};
   assign in_v = {req_item.box_top, req_item.box_bottom};
   assign in_ok = (req_item.score >= threshold) && (req_item.box_right > req_item.box_left)
      && (req_item.box_bottom > req_item.box_top);

   always_comb begin
      for (int k = 0; k < RANK_DEPTH; k++) begin
         below[k] = (k >= int'(rank_count_ff)) || (rank_score_ff[k] < req_item.score);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.insert && in_ok) begin
         for (int k = 0; k < RANK_DEPTH; k++) begin
            if (below[k]) begin
               if (k == 0 || !below[k-1]) begin
                  rank_score_ff[k] <= req_item.score;
                  rank_h_ff[k] <= in_h;
                  rank_v_ff[k] <= in_v;
               end else begin
                  rank_score_ff[k] <= rank_score_ff[k-1];
                  rank_h_ff[k] <= rank_h_ff[k-1];
                  rank_v_ff[k] <= rank_v_ff[k-1];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_rank || cmd.clear_all) begin
         rank_count_ff <= '0;
      end else if (cmd.insert && in_ok && below[RANK_DEPTH-1]
            && rank_count_ff < RankBits'(RANK_DEPTH)) begin
         rank_count_ff <= rank_count_ff + 1'b1;
      end
   end

   logic [16:0] kl, kr, kt, kb, cl, cr, ct, cb;
   logic [16:0] ox_lo, ox_hi, oy_lo, oy_hi, ow, oh, aw, ah, bw, bh;
   logic [KeepIdx-1:0] cmp_idx;
   assign cmp_idx = cmp_ff[KeepIdx-1:0];
   assign {kl, kr} = kept_h_ff[cmp_idx];
   assign {kt, kb} = kept_v_ff[cmp_idx];
   assign {cl, cr} = c_h_ff;
   assign {ct, cb} = c_v_ff;
   assign ox_lo = (cl > kl) ? cl : kl;
   assign ox_hi = (cr < kr) ? cr : kr;
   assign oy_lo = (ct > kt) ? ct : kt;
   assign oy_hi = (cb < kb) ? cb : kb;
   assign ow = (ox_hi > ox_lo) ? ox_hi - ox_lo : '0;
   assign oh = (oy_hi > oy_lo) ? oy_hi - oy_lo : '0;
   assign aw = (cr > cl) ? cr - cl : '0;
   assign ah = (cb > ct) ? cb - ct : '0;
   assign bw = (kr > kl) ? kr - kl : '0;
   assign bh = (kb > kt) ? kb - kt : '0;

   logic [35:0] uni;
   logic [34:0] sum_ab;
   logic [52:0] lhs, rhs;
   assign sum_ab = {1'b0, area_a_ff} + {1'b0, area_b_ff};
   assign uni = ({1'b0, sum_ab} > {2'b0, inter_ff}) ? ({1'b0, sum_ab} - {2'b0, inter_ff})
      : 36'd0;
   assign lhs = {3'b0, inter_ff, 16'b0};
   assign rhs = 53'(limit) * 53'((uni == 36'd0) ? 36'd1 : uni);

   logic [RankIdx-1:0] cand_idx;
   assign cand_idx = cand_ff[RankIdx-1:0];

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all) begin
         kept_count_ff <= '0;
         role_ff <= 1'b0;
         base_ff <= '0;
      end else begin
         if (cmd.set_role) begin
            role_ff <= req_item.role;
            base_ff <= kept_count_ff;
         end
         if (cmd.keep) begin
            kept_count_ff <= kept_count_ff + 1'b1;
         end
      end
      if (cmd.keep) begin
         kept_score_ff[kept_count_ff[KeepIdx-1:0]] <= c_score_ff;
         kept_h_ff[kept_count_ff[KeepIdx-1:0]] <= c_h_ff;
         kept_v_ff[kept_count_ff[KeepIdx-1:0]] <= c_v_ff;
         kept_role_ff[kept_count_ff[KeepIdx-1:0]] <= role_ff;
      end
      if (cmd.start_cand) begin
         cand_ff <= '0;
         taken_ff <= '0;
      end else if (cmd.next_cand) begin
         cand_ff <= cand_ff + 1'b1;
      end
      if (cmd.keep) begin
         taken_ff <= taken_ff + 1'b1;
      end
      if (cmd.start_cmp) begin
         c_score_ff <= rank_score_ff[cand_idx];
         c_h_ff <= rank_h_ff[cand_idx];
         c_v_ff <= rank_v_ff[cand_idx];
         cmp_ff <= base_ff;
         hit_ff <= 1'b0;
         mul_valid_ff <= 1'b0;
      end else if (cmd.step_cmp) begin
         if (!mul_valid_ff) begin
            inter_ff <= 34'(ow) * 34'(oh);
            area_a_ff <= 34'(aw) * 34'(ah);
            area_b_ff <= 34'(bw) * 34'(bh);
            mul_valid_ff <= 1'b1;
         end else begin
            hit_ff <= lhs > rhs;
            cmp_ff <= cmp_ff + 1'b1;
            mul_valid_ff <= 1'b0;
         end
      end
   end

   logic [KeepBits-1:0] emit_cur, emit_next;
   logic [KeepIdx-1:0] emit_sel;
   assign emit_cur = cmd.start_emit ? '0 : emit_ff + 1'b1;
   assign emit_next = emit_cur + 1'b1;
   assign emit_sel = emit_cur[KeepIdx-1:0];

   always_ff @(posedge clock) begin
      if (cmd.start_emit) begin
         emit_ff <= '0;
      end else if (cmd.emit_step) begin
         emit_ff <= emit_ff + 1'b1;
      end
      if (cmd.start_emit || cmd.emit_step) begin
         if (kept_count_ff == '0) begin
            rsp_ff.present <= 1'b0;
            rsp_ff.out_role <= 1'b0;
            rsp_ff.out_score <= '0;
            rsp_ff.out_left <= '0;
            rsp_ff.out_right <= '0;
            rsp_ff.out_top <= '0;
            rsp_ff.out_bottom <= '0;
            rsp_ff.last_result <= 1'b1;
         end else begin
            rsp_ff.present <= 1'b1;
            rsp_ff.out_role <= kept_role_ff[emit_sel];
            rsp_ff.out_score <= kept_score_ff[emit_sel];
            rsp_ff.out_left <= kept_h_ff[emit_sel][33:17];
            rsp_ff.out_right <= kept_h_ff[emit_sel][16:0];
            rsp_ff.out_top <= kept_v_ff[emit_sel][33:17];
            rsp_ff.out_bottom <= kept_v_ff[emit_sel][16:0];
            rsp_ff.last_result <= (emit_next == kept_count_ff);
         end
      end
   end

   assign status.rank_empty = (rank_count_ff == '0);
   assign status.cand_done = (cand_ff >= rank_count_ff)
      || (taken_ff >= TakeBits'(KEEP_PER_ROLE))
      || (kept_count_ff >= KeepBits'(KeepDepth));
   assign status.cmp_done = (cmp_ff >= kept_count_ff) && !mul_valid_ff;
   assign status.cmp_hit = hit_ff;
   assign status.emit_last = rsp_ff.last_result;
   assign status.kept_empty = (kept_count_ff == '0);
   assign rsp_item = rsp_ff;
   assign cur_role = role_ff;

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset) kept_count_ff <= KeepBits'(KeepDepth))
      else $error("kept count beyond store depth");
   assert property (@(posedge clock) disable iff (reset)
      rank_count_ff <= RankBits'(RANK_DEPTH)) else $error("rank count beyond depth");
   assert property (@(posedge clock) disable iff (reset) cmd.keep |-> !hit_ff)
      else $error("suppressed box kept");
`endif
endmodule

[src/dbs_controller.sv]
// Controller state machine sequencing insertion, suppression and result emission.
// Depends on dbs_pkg for the command and status structs.
module dbs_controller #(
   parameter int unsigned ROLE_COUNT = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_role,
   input  logic                req_end,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic                cur_role,
   input  dbs_pkg::status_type status,
   output dbs_pkg::cmd_type    cmd
);
   typedef enum logic [2:0] {
      S_IDLE, S_CAND, S_CMP, S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      after_ff, after_in;
   logic      item_ff, item_in;
   logic      rsp_valid_ff, rsp_valid_in;

   logic accept, in_range, role_change;
   assign in_range = (ROLE_COUNT > 1) || (req_role == 1'b0);
   assign role_change = req_valid && in_range && (req_role != cur_role);
   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff && !role_change;
   assign accept = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      after_in = after_ff;
      item_in = item_ff;
      rsp_valid_in = rsp_valid_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (role_change && state_ff == S_IDLE && !rsp_valid_ff) begin
               cmd.start_cand = 1'b1;
               item_in = 1'b1;
               after_in = 1'b0;
               state_in = S_CAND;
            end else if (accept) begin
               cmd.insert = in_range;
               if (req_end) begin
                  cmd.start_cand = 1'b1;
                  item_in = 1'b0;
                  after_in = 1'b1;
                  state_in = S_CAND;
               end
            end
         end
         S_CAND: begin
            if (status.cand_done) begin
               cmd.clear_rank = 1'b1;
               if (after_ff) begin
                  cmd.start_emit = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in = S_EMIT;
               end else begin
                  cmd.set_role = item_ff;
                  item_in = 1'b0;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.start_cmp = 1'b1;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (status.cmp_hit) begin
               cmd.next_cand = 1'b1;
               state_in = S_CAND;
            end else if (status.cmp_done) begin
               cmd.keep = 1'b1;
               cmd.next_cand = 1'b1;
               state_in = S_CAND;
            end else begin
               cmd.step_cmp = 1'b1;
            end
         end
         S_EMIT: begin
            if (rsp_ready) begin
               if (status.emit_last) begin
                  rsp_valid_in = 1'b0;
                  cmd.clear_all = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  cmd.emit_step = 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         after_ff <= 1'b0;
         item_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         after_ff <= after_in;
         item_ff <= item_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset) rsp_valid_ff |-> state_ff == S_EMIT)
      else $error("result shown outside emission");
   assert property (@(posedge clock) disable iff (reset) cmd.keep |-> status.cmp_done)
      else $error("keep before compare finished");
   assert property (@(posedge clock) disable iff (reset) req_ready |-> !rsp_valid_ff)
      else $error("item taken during emission");
`endif
endmodule

[tb/testbench.sv]
// Self-checking testbench for detection_box_suppression: streams grid cells, writes the
// score threshold and overlap limit over the register port, and checks every kept box.
// Depends on dbs_pkg, dbs_stream_if and the block itself.
module testbench;
   localparam int unsigned RankDepth = 64;
   localparam int unsigned KeepPerRole = 8;
   localparam int unsigned KeepDepth = 16;
   localparam longint unsigned CycleLimit = 3000000;

   class box_scoreboard;
      logic [16:0] threshold;
      logic [16:0] limit;
      logic [16:0] rank_score[$];
      logic [33:0] rank_horiz[$];
      logic [33:0] rank_vert[$];
      logic [16:0] keep_score[$];
      logic [33:0] keep_horiz[$];
      logic [33:0] keep_vert[$];
      logic        keep_role[$];
      logic        role_now;
      dbs_pkg::rsp_type pending[$];
      int          errors;

      function new();
         threshold = dbs_pkg::ThresholdReset;
         limit = dbs_pkg::LimitReset;
         role_now = 1'b0;
         errors = 0;
      endfunction

      function automatic longint unsigned extent(longint unsigned lo, longint unsigned hi);
         return hi > lo ? hi - lo : 0;
      endfunction

      function automatic bit overlapping(logic [33:0] ha, logic [33:0] va,
                                         logic [33:0] hb, logic [33:0] vb);
         longint unsigned lo_h, hi_h, lo_v, hi_v, inter, area_a, area_b, uni;
         lo_h = (ha[33:17] > hb[33:17]) ? ha[33:17] : hb[33:17];
         hi_h = (ha[16:0] < hb[16:0]) ? ha[16:0] : hb[16:0];
         lo_v = (va[33:17] > vb[33:17]) ? va[33:17] : vb[33:17];
         hi_v = (va[16:0] < vb[16:0]) ? va[16:0] : vb[16:0];
         inter = extent(lo_h, hi_h) * extent(lo_v, hi_v);
         area_a = extent(ha[33:17], ha[16:0]) * extent(va[33:17], va[16:0]);
         area_b = extent(hb[33:17], hb[16:0]) * extent(vb[33:17], vb[16:0]);
         uni = area_a + area_b;
         uni = uni > inter ? uni - inter : 0;
         if (uni < 1) uni = 1;
         return (inter << 16) > longint'(limit) * uni;
      endfunction

      function void suppress_role();
         int base;
         int taken;
         bit ok;
         base = keep_score.size();
         taken = 0;
         foreach (rank_score[i]) begin
            if (taken >= KeepPerRole || keep_score.size() >= KeepDepth) break;
            ok = 1;
            for (int j = base; j < keep_score.size(); j++)
               if (overlapping(rank_horiz[i], rank_vert[i], keep_horiz[j], keep_vert[j]))
                  ok = 0;
            if (ok) begin
               keep_score.insert(keep_score.size(), rank_score[i]);
               keep_horiz.insert(keep_horiz.size(), rank_horiz[i]);
               keep_vert.insert(keep_vert.size(), rank_vert[i]);
               keep_role.insert(keep_role.size(), role_now);
               taken++;
            end
         end
         rank_score.delete();
         rank_horiz.delete();
         rank_vert.delete();
      endfunction

      function void note_cell(dbs_pkg::req_type c);
         int pos;
         dbs_pkg::rsp_type r;
         if (c.role != role_now) begin
            suppress_role();
            role_now = c.role;
         end
         if (c.score >= threshold && c.box_right > c.box_left && c.box_bottom > c.box_top) begin
            pos = 0;
            while (pos < rank_score.size() && rank_score[pos] >= c.score) pos++;
            if (pos < RankDepth) begin
               rank_score.insert(pos, c.score);
               rank_horiz.insert(pos, {c.box_left, c.box_right});
               rank_vert.insert(pos, {c.box_top, c.box_bottom});
               if (rank_score.size() > RankDepth) begin
                  void'(rank_score.pop_back());
                  void'(rank_horiz.pop_back());
                  void'(rank_vert.pop_back());
               end
            end
         end
         if (!c.frame_end) return;
         suppress_role();
         if (keep_score.size() == 0) begin
            r = '0;
            r.last_result = 1'b1;
            pending.insert(pending.size(), r);
         end else begin
            foreach (keep_score[k]) begin
               r.present = 1'b1;
               r.out_role = keep_role[k];
               r.out_score = keep_score[k];
               r.out_left = keep_horiz[k][33:17];
               r.out_right = keep_horiz[k][16:0];
               r.out_top = keep_vert[k][33:17];
               r.out_bottom = keep_vert[k][16:0];
               r.last_result = (k == keep_score.size() - 1);
               pending.insert(pending.size(), r);
            end
         end
         keep_score.delete();
         keep_horiz.delete();
         keep_vert.delete();
         keep_role.delete();
         role_now = 1'b0;
      endfunction

      function void check_box(dbs_pkg::rsp_type got);
         dbs_pkg::rsp_type w;
         if (pending.size() == 0) begin
            $error("unexpected result item %h", got);
            errors++;
            return;
         end
         w = pending.pop_front();
         if (got.present !== w.present) begin
            $error("present: expected %0d actual %0d", w.present, got.present); errors++;
         end
         if (got.out_role !== w.out_role) begin
            $error("out_role: expected %0d actual %0d", w.out_role, got.out_role); errors++;
         end
         if (got.out_score !== w.out_score) begin
            $error("out_score: expected %0d actual %0d", w.out_score, got.out_score); errors++;
         end
         if (got.out_left !== w.out_left) begin
            $error("out_left: expected %0d actual %0d", w.out_left, got.out_left); errors++;
         end
         if (got.out_top !== w.out_top) begin
            $error("out_top: expected %0d actual %0d", w.out_top, got.out_top); errors++;
         end
         if (got.out_right !== w.out_right) begin
            $error("out_right: expected %0d actual %0d", w.out_right, got.out_right); errors++;
         end
         if (got.out_bottom !== w.out_bottom) begin
            $error("out_bottom: expected %0d actual %0d", w.out_bottom, got.out_bottom);
            errors++;
         end
         if (got.last_result !== w.last_result) begin
            $error("last_result: expected %0d actual %0d", w.last_result, got.last_result);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   longint unsigned cycles = 0;
   bit          quiet_rsp = 0;
   bit          quiet_req = 0;
   int          hold_cycles = 0;
   box_scoreboard board;

   dbs_stream_if #(.payload_type(dbs_pkg::req_type)) req_ch (clock);
   dbs_stream_if #(.payload_type(dbs_pkg::rsp_type)) rsp_ch (clock);

   detection_box_suppression u_top (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      board = new();
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("testbench failed");
         $finish;
      end
      if (!reset && req_ch.valid && req_ch.ready) board.note_cell(req_ch.payload);
      if (!reset && rsp_ch.valid && rsp_ch.ready) board.check_box(rsp_ch.payload);
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= quiet_rsp ? 1'b1 : ($urandom_range(99) >= 35);
      end
   end

   task automatic write_reg(dbs_pkg::reg_index_type idx, logic [16:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= 3'(4 * int'(idx));
      csr_pwdata <= 32'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == dbs_pkg::REG_THRESHOLD) board.threshold = value;
      else board.limit = value;
   endtask

   // Called at a falling edge; returns at the falling edge after the item is taken, with
   // valid still high so that the next item can follow without a gap.
   task automatic send_cell(dbs_pkg::req_type c);
      while (!quiet_req && $urandom_range(99) < 35) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= c;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [16:0] edge_value();
      case ($urandom_range(9))
         0: return 17'd0;
         1: return 17'd65536;
         2: return 17'h1FFFF;
         default: return 17'($urandom_range(65536));
      endcase
   endfunction

   function automatic dbs_pkg::req_type random_cell(logic role, bit noisy);
      dbs_pkg::req_type c;
      logic [16:0] a, b, w, h;
      c.role = role;
      c.frame_end = 1'b0;
      if (noisy) begin
         c.score = 17'($urandom());
         c.box_left = edge_value();
         c.box_top = edge_value();
         c.box_right = edge_value();
         c.box_bottom = edge_value();
      end else begin
         c.score = ($urandom_range(3) == 0) ? 17'($urandom_range(49152))
                                            : 17'($urandom_range(65536, 40000));
         a = 17'($urandom_range(50000));
         b = 17'($urandom_range(50000));
         w = 17'($urandom_range(15000, 1));
         h = 17'($urandom_range(15000, 1));
         c.box_left = a;
         c.box_top = b;
         c.box_right = a + w;
         c.box_bottom = b + h;
      end
      return c;
   endfunction

   // Called at a falling edge right after the last send_cell.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic send_frame(int count);
      dbs_pkg::req_type c;
      logic role;
      role = 1'b0;
      for (int i = 0; i < count; i++) begin
         if (role == 1'b0 && $urandom_range(count) == 0) role = 1'b1;
         if ($urandom_range(19) == 0) role = ~role;
         c = random_cell(role, $urandom_range(9) < 2);
         c.frame_end = (i == count - 1);
         send_cell(c);
      end
   endtask

   initial begin
      dbs_pkg::req_type c;
      int sent;
      bit reconfigured;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extreme fields, invalid boxes, ties, role return and an empty frame.
      c = '0; c.frame_end = 1'b1;
      send_cell(c);
      c = '0; c.score = 17'd65536; c.box_right = 17'd65536; c.box_bottom = 17'd65536;
      send_cell(c);
      send_cell(c);
      c.score = 17'h1FFFF; c.box_left = 17'h1FFFF; c.box_right = 17'h1FFFF;
      send_cell(c);
      c = '0; c.score = 17'd49152; c.box_left = 17'd10; c.box_right = 17'd20;
      c.box_top = 17'd30; c.box_bottom = 17'd40;
      send_cell(c);
      c.score = 17'd49151;
      send_cell(c);
      c.role = 1'b1; c.score = 17'd60000; c.box_right = 17'h1FFFF; c.box_bottom = 17'h1FFFF;
      send_cell(c);
      c.role = 1'b0; c.score = 17'd50000; c.box_left = 17'd0; c.box_right = 17'd100;
      send_cell(c);
      c.role = 1'b1; c.frame_end = 1'b1; c.box_left = 17'd5; c.box_right = 17'd4;
      send_cell(c);
      drain();

      write_reg(dbs_pkg::REG_THRESHOLD, 17'd32768);
      write_reg(dbs_pkg::REG_LIMIT, 17'd0);
      send_frame(12);
      drain();
      write_reg(dbs_pkg::REG_LIMIT, 17'd65536);
      write_reg(dbs_pkg::REG_THRESHOLD, 17'd65536);
      send_frame(10);
      drain();
      write_reg(dbs_pkg::REG_THRESHOLD, 17'd40000);
      write_reg(dbs_pkg::REG_LIMIT, dbs_pkg::LimitReset);

      // Long receiver hold while cells keep coming, so the block backs up.
      hold_cycles = 3000;
      quiet_req = 1;
      send_frame(30);
      send_frame(30);
      quiet_req = 0;
      drain();

      sent = 0;
      reconfigured = 0;
      while (sent < 200) begin
         if (!reconfigured && sent >= 100) begin
            drain();
            write_reg(dbs_pkg::REG_THRESHOLD, 17'($urandom_range(65536, 32768)));
            write_reg(dbs_pkg::REG_LIMIT, 17'($urandom_range(65536)));
            quiet_rsp = 1;
            reconfigured = 1;
         end
         if (sent >= 150) quiet_rsp = 0;
         begin
            int n;
            n = ($urandom_range(9) == 0) ? 80 : $urandom_range(20, 1);
            send_frame(n);
            sent += n;
         end
      end
      drain();
      if (board.errors == 0) $display("testbench passed");
      else $display("testbench failed");
      $finish;
   end
endmodule
